/* rtl/bpbcd_pkg.sv */
// Shared types, constants and helper functions for the binary to packed BCD encoder.
// Holds the double-dabble step function and the per-byte-count fit limits.
// No dependencies.
package bpbcd_pkg;

  localparam int MAX_BCD_BYTES = 10;
  localparam int BinBits       = 64;
  localparam int Digits        = 20;
  localparam int BcdBits       = 4 * Digits;
  localparam int LowBits       = 64;
  localparam int HighBits      = BcdBits - LowBits;
  localparam int StepBits      = 8;
  localparam int NumStages     = BinBits / StepBits;
  localparam int CountBits     = 4;

  localparam logic [CountBits-1:0] MaxBytesCode = CountBits'(MAX_BCD_BYTES);
  localparam logic [CountBits-1:0] AllFitBytes  = 4'd10;
  localparam logic [CountBits-1:0] ResetBytes   = 4'd10;

  typedef struct packed {
    logic [BinBits-1:0] bin;
    logic [BcdBits-1:0] bcd;
    logic               fits;
  } dabble_t;

  // Largest value that fits in n packed BCD bytes, i.e. 10^(2n)-1, for n of 1 to 9; any other n gives all ones.
  function automatic logic [BinBits-1:0] fit_limit(input logic [CountBits-1:0] n);
    logic [BinBits-1:0] lim;
    case (n)
      4'd1:    lim = 64'd99;
      4'd2:    lim = 64'd9999;
      4'd3:    lim = 64'd999999;
      4'd4:    lim = 64'd99999999;
      4'd5:    lim = 64'd9999999999;
      4'd6:    lim = 64'd999999999999;
      4'd7:    lim = 64'd99999999999999;
      4'd8:    lim = 64'd9999999999999999;
      4'd9:    lim = 64'd999999999999999999;
      default: lim = {BinBits{1'b1}};
    endcase
    return lim;
  endfunction

  // Advance the shift-add-3 conversion by StepBits input bits.
  function automatic dabble_t dabble_step(input dabble_t cur);
    dabble_t r;
    r = cur;
    for (int i = 0; i < StepBits; i++) begin
      for (int d = 0; d < Digits; d++) begin
        if (r.bcd[4*d +: 4] >= 4'd5) begin
          r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BcdBits-2:0], r.bin[BinBits-1]};
      r.bin = {r.bin[BinBits-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/binary_to_packed_bcd_encoder.sv */
// Top level of the binary to packed BCD encoder: input fit check and pipelined double dabble.
// Depends on bpbcd_pkg for types, constants, the fit limit table and the step function.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one 64-bit unsigned value per transfer.
//   Master stream (m_tvalid/m_tready/m_tdata) returns one result per input value:
//   the 20-digit packed BCD form (tens digit in the high nibble of each byte) and a fit flag.
//   byte_count_wr_en/byte_count_wr_data write the field length in bytes (1..10, reset 10);
//   write it only while the pipeline is empty. Counts above 10 act as 10, zero fits nothing.
//   A value above 10^(2*bytes)-1 returns all-zero digits with value_fits cleared.
// Timing:
//   From the input transfer to m_tvalid, one stage registers the value
//   and its fit flag, then eight stages each convert eight bits of the value.
//   Throughput is one transfer per cycle while m_tready is high; every stage holds a valid bit and data.
// Reset:
//   rst (synchronous, active high) clears all valid bits and sets byte_count to 10.
// Stall:
//   When m_tready is low the output holds; stages behind it keep filling any empty slots,
//   and s_tready drops only once every stage holds an item. Nothing is lost or repeated.
module binary_to_packed_bcd_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,            // [63:0] binary_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,            // [63:0] bcd_low_digits, [79:64] bcd_high_digits,
                                          // [80] value_fits, [87:81] zero
  input  logic        byte_count_wr_en,
  input  logic [3:0]  byte_count_wr_data
);

  logic [bpbcd_pkg::CountBits-1:0] byte_count;
  logic [bpbcd_pkg::CountBits-1:0] bytes_eff;
  logic                            in_fits;

  logic                            valid [0:bpbcd_pkg::NumStages];
  logic                            ready [0:bpbcd_pkg::NumStages];
  bpbcd_pkg::dabble_t              stage [0:bpbcd_pkg::NumStages];
  bpbcd_pkg::dabble_t              load;

  // Field length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= bpbcd_pkg::ResetBytes;
    end else if (byte_count_wr_en) begin
      byte_count <= byte_count_wr_data;
    end
  end

  // Saturate the count, then compare against the limit for that many bytes.
  always_comb begin
    if (byte_count > bpbcd_pkg::MaxBytesCode) begin
      bytes_eff = bpbcd_pkg::MaxBytesCode;
    end else begin
      bytes_eff = byte_count;
    end
    in_fits = (bytes_eff != '0) &&
              ((bytes_eff >= bpbcd_pkg::AllFitBytes) ||
               (s_tdata <= bpbcd_pkg::fit_limit(bytes_eff)));
    load.bin  = s_tdata;
    load.bcd  = '0;
    load.fits = in_fits;
  end

  // A stage may take new data when it is empty or its content moves on this cycle.
  always_comb begin
    ready[bpbcd_pkg::NumStages] = !valid[bpbcd_pkg::NumStages] || m_tready;
    for (int i = bpbcd_pkg::NumStages - 1; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign s_tready = ready[0];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= bpbcd_pkg::NumStages; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      if (ready[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int i = 1; i <= bpbcd_pkg::NumStages; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // Data path: load on input transfer, then advance eight bits per stage.
  always_ff @(posedge clk) begin
    if (s_tvalid && ready[0]) begin
      stage[0] <= load;
    end
    for (int i = 1; i <= bpbcd_pkg::NumStages; i++) begin
      if (ready[i] && valid[i-1]) begin
        stage[i] <= bpbcd_pkg::dabble_step(stage[i-1]);
      end
    end
  end

  // Drop the digits when the value does not fit the field.
  assign m_tvalid = valid[bpbcd_pkg::NumStages];
  assign m_tdata  = {7'b0,
                     stage[bpbcd_pkg::NumStages].fits,
                     stage[bpbcd_pkg::NumStages].bcd &
                       {bpbcd_pkg::BcdBits{stage[bpbcd_pkg::NumStages].fits}}};

endmodule
